// ----- sv/psp_pkg.sv -----
package psp_pkg;

  // Per-item control that travels down the pipeline beside the data
  typedef struct packed {
    logic valid;
    logic on_segment;
    logic degenerate;
  } flags_t;

endpackage

// ----- sv/psp_req_if.sv -----
interface psp_req_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] start_z;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] end_z;

  modport source (output valid, point_x, point_y, point_z, start_x, start_y, start_z,
                  end_x, end_y, end_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, start_x, start_y, start_z,
                end_x, end_y, end_z, output ready);
endinterface

// ----- sv/psp_rsp_if.sv -----
interface psp_rsp_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] proj_x;
  logic signed [COORD_WIDTH-1:0] proj_y;
  logic signed [COORD_WIDTH-1:0] proj_z;
  logic                          on_segment;
  logic                          degenerate;

  modport source (output valid, proj_x, proj_y, proj_z, on_segment, degenerate,
                  input ready);
  modport sink (input valid, proj_x, proj_y, proj_z, on_segment, degenerate,
                output ready);
endinterface

// ----- sv/psp_front.sv -----
module psp_front #(
  parameter int COORD_WIDTH = 32,
  parameter int REM_WIDTH   = 2 * COORD_WIDTH + 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [COORD_WIDTH-1:0]          p [3],
  input  logic [COORD_WIDTH-1:0]          a [3],
  input  logic [COORD_WIDTH-1:0]          b [3],
  output psp_pkg::flags_t                 flags,
  output logic [REM_WIDTH-1:0]            num,
  output logic [REM_WIDTH-1:0]            den,
  output logic signed [COORD_WIDTH:0]     d_out [3],
  output logic [COORD_WIDTH-1:0]          a_out [3]
);
  import psp_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 2;

  logic                  v1, v2;
  logic signed [DW-1:0]  q1 [3];
  logic signed [DW-1:0]  d1 [3];
  logic [COORD_WIDTH-1:0] a1 [3];
  logic signed [PW-1:0]  qd2 [3];
  logic signed [PW-1:0]  dd2 [3];
  logic signed [DW-1:0]  d2 [3];
  logic [COORD_WIDTH-1:0] a2 [3];
  logic signed [NW-1:0]  num_sum;
  logic signed [NW-1:0]  den_sum;

  // Sum the three products at full width
  always_comb begin
    num_sum = NW'(qd2[0]) + NW'(qd2[1]) + NW'(qd2[2]);
    den_sum = NW'(dd2[0]) + NW'(dd2[1]) + NW'(dd2[2]);
  end

  // Advance valid bits; stage 1 differences, stage 2 products,
  // stage 3 dot products and range test
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      flags.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      flags.valid <= v2;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q1[i]  <= $signed({p[i][COORD_WIDTH-1], p[i]}) - $signed({a[i][COORD_WIDTH-1], a[i]});
        d1[i]  <= $signed({b[i][COORD_WIDTH-1], b[i]}) - $signed({a[i][COORD_WIDTH-1], a[i]});
        a1[i]  <= a[i];
        qd2[i] <= q1[i] * d1[i];
        dd2[i] <= d1[i] * d1[i];
        d2[i]  <= d1[i];
        a2[i]  <= a1[i];
        d_out[i] <= d2[i];
        a_out[i] <= a2[i];
      end
      num <= num_sum[REM_WIDTH-1:0];
      den <= den_sum[REM_WIDTH-1:0];
      flags.degenerate <= (den_sum == '0);
      flags.on_segment <= !num_sum[NW-1] && (num_sum < den_sum);
    end
  end
endmodule

// ----- sv/psp_div_step.sv -----
module psp_div_step #(
  parameter int COORD_WIDTH = 32,
  parameter int REM_WIDTH   = 2 * COORD_WIDTH + 3,
  parameter int T_FRAC_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  psp_pkg::flags_t                 flags_in,
  input  logic [REM_WIDTH-1:0]            rem_in,
  input  logic [REM_WIDTH-1:0]            den_in,
  input  logic [T_FRAC_BITS-1:0]          t_in,
  input  logic signed [COORD_WIDTH:0]     d_in [3],
  input  logic [COORD_WIDTH-1:0]          a_in [3],
  output psp_pkg::flags_t                 flags,
  output logic [REM_WIDTH-1:0]            rem,
  output logic [REM_WIDTH-1:0]            den,
  output logic [T_FRAC_BITS-1:0]          t,
  output logic signed [COORD_WIDTH:0]     d_out [3],
  output logic [COORD_WIDTH-1:0]          a_out [3]
);
  import psp_pkg::*;

  logic [REM_WIDTH-1:0] shifted;
  logic                 fits;

  // One restoring quotient bit
  always_comb begin
    shifted = {rem_in[REM_WIDTH-2:0], 1'b0};
    fits    = (shifted >= den_in);
  end

  // Advance the valid bit and the data
  always_ff @(posedge clk) begin
    if (rst) begin
      flags.valid <= 1'b0;
    end else if (en) begin
      flags.valid <= flags_in.valid;
    end
    if (en) begin
      flags.on_segment <= flags_in.on_segment;
      flags.degenerate <= flags_in.degenerate;
      rem   <= fits ? shifted - den_in : shifted;
      den   <= den_in;
      t     <= {t_in[T_FRAC_BITS-2:0], fits};
      d_out <= d_in;
      a_out <= a_in;
    end
  end
endmodule

// ----- sv/psp_back.sv -----
module psp_back #(
  parameter int COORD_WIDTH = 32,
  parameter int T_FRAC_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  psp_pkg::flags_t                 flags_in,
  input  logic [T_FRAC_BITS-1:0]          t_in,
  input  logic signed [COORD_WIDTH:0]     d_in [3],
  input  logic [COORD_WIDTH-1:0]          a_in [3],
  output psp_pkg::flags_t                 flags,
  output logic [COORD_WIDTH-1:0]          proj [3]
);
  import psp_pkg::*;

  localparam int MW = T_FRAC_BITS + COORD_WIDTH + 2;

  flags_t                 flags1;
  logic signed [MW-1:0]   prod [3];
  logic [COORD_WIDTH-1:0] a1 [3];
  logic signed [MW-1:0]   off [3];

  // Floor the scaled offset
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i] = prod[i] >>> T_FRAC_BITS;
    end
  end

  // Advance valid bits; multiply t by the direction, then add the start point (zero when off the segment)
  always_ff @(posedge clk) begin
    if (rst) begin
      flags1.valid <= 1'b0;
      flags.valid  <= 1'b0;
    end else if (en) begin
      flags1.valid <= flags_in.valid;
      flags.valid  <= flags1.valid;
    end
    if (en) begin
      flags1.on_segment <= flags_in.on_segment;
      flags1.degenerate <= flags_in.degenerate;
      flags.on_segment  <= flags1.on_segment;
      flags.degenerate  <= flags1.degenerate;
      for (int i = 0; i < 3; i++) begin
        prod[i] <= MW'($signed({1'b0, t_in}) * d_in[i]);
        a1[i]   <= a_in[i];
        proj[i] <= flags1.on_segment ? a1[i] + off[i][COORD_WIDTH-1:0] : '0;
      end
    end
  end
endmodule

// ----- sv/point_segment_projection_top.sv -----
// Throughput: one request per cycle while the output is not stalled;
// one quotient bit is formed per divider stage.
// A stalled output holds the whole pipeline in place, nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module point_segment_projection_top #(
  parameter int COORD_WIDTH = 32,
  parameter int T_FRAC_BITS = 32
) (
  input logic clk,
  input logic rst,
  psp_req_if.sink   req,
  psp_rsp_if.source rsp
);
  import psp_pkg::*;

  localparam int RW = 2 * COORD_WIDTH + 3;

  logic                   en;
  logic [COORD_WIDTH-1:0] p [3];
  logic [COORD_WIDTH-1:0] a [3];
  logic [COORD_WIDTH-1:0] b [3];
  logic [COORD_WIDTH-1:0] proj [3];
  flags_t                 out_flags;

  flags_t                     st_flags [T_FRAC_BITS+1];
  logic [RW-1:0]              st_rem   [T_FRAC_BITS+1];
  logic [RW-1:0]              st_den   [T_FRAC_BITS+1];
  logic [T_FRAC_BITS-1:0]     st_t     [T_FRAC_BITS+1];
  logic signed [COORD_WIDTH:0] st_d    [T_FRAC_BITS+1][3];
  logic [COORD_WIDTH-1:0]     st_a     [T_FRAC_BITS+1][3];

  // Advance whenever the output register is free or being drained
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  assign p = '{req.point_x, req.point_y, req.point_z};
  assign a = '{req.start_x, req.start_y, req.start_z};
  assign b = '{req.end_x, req.end_y, req.end_z};
  assign st_t[0] = '0;

  psp_front #(.COORD_WIDTH(COORD_WIDTH), .REM_WIDTH(RW)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(req.valid),
    .p(p), .a(a), .b(b),
    .flags(st_flags[0]), .num(st_rem[0]), .den(st_den[0]),
    .d_out(st_d[0]), .a_out(st_a[0])
  );

  for (genvar k = 0; k < T_FRAC_BITS; k++) begin : g_div
    psp_div_step #(.COORD_WIDTH(COORD_WIDTH), .REM_WIDTH(RW), .T_FRAC_BITS(T_FRAC_BITS)) u_step (
      .clk(clk), .rst(rst), .en(en),
      .flags_in(st_flags[k]), .rem_in(st_rem[k]), .den_in(st_den[k]), .t_in(st_t[k]),
      .d_in(st_d[k]), .a_in(st_a[k]),
      .flags(st_flags[k+1]), .rem(st_rem[k+1]), .den(st_den[k+1]), .t(st_t[k+1]),
      .d_out(st_d[k+1]), .a_out(st_a[k+1])
    );
  end

  psp_back #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .en(en),
    .flags_in(st_flags[T_FRAC_BITS]), .t_in(st_t[T_FRAC_BITS]),
    .d_in(st_d[T_FRAC_BITS]), .a_in(st_a[T_FRAC_BITS]),
    .flags(out_flags), .proj(proj)
  );

  assign rsp.valid      = out_flags.valid;
  assign rsp.on_segment = out_flags.on_segment;
  assign rsp.degenerate = out_flags.degenerate;
  assign rsp.proj_x     = proj[0];
  assign rsp.proj_y     = proj[1];
  assign rsp.proj_z     = proj[2];
endmodule
